[sv/kri_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kri_pkg
// Shared types and constants for the keyframe rate interpolator.
// ----------------------------------------------------------------------------
package kri_pkg;

  localparam int MAX_KEYS   = 256;
  localparam int KEY_IDX_W  = $clog2(MAX_KEYS);
  localparam int KEY_CNT_W  = KEY_IDX_W + 1;
  localparam int FRAME_W    = 24;
  localparam int RATE_W     = 16;
  localparam int ENTRY_W    = FRAME_W + RATE_W;
  localparam int ACC_W      = FRAME_W + RATE_W;
  localparam int STEP_W     = $clog2(RATE_W);
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [RATE_W-1:0] RATE_ONE      = 16'h8000;
  localparam logic [RATE_W-1:0] THRESH_RESET  = 16'd32;

  // register word index (paddr[2])
  localparam logic REG_THRESH = 1'b0;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_CLEAR = 2'd2
  } kri_req_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_FULL  = 2'd1,
    ACT_BLEND = 2'd2
  } kri_action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } kri_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_LAST_RD,
    S_SCAN,
    S_INTERP,
    S_RESULT
  } kri_state_e;

  typedef enum logic [2:0] {
    I_IDLE,
    I_MUL_A,
    I_MUL_B,
    I_NORM,
    I_DIV,
    I_DONE
  } kri_istate_e;

  typedef struct packed {
    logic              start;
    logic [RATE_W-1:0] rate_prev;
    logic [RATE_W-1:0] rate_cur;
    logic [FRAME_W-1:0] span;    // frame[cur] - frame[prev]
    logic [FRAME_W-1:0] offs;    // q - frame[prev]
  } kri_ireq_t;

  typedef struct packed {
    logic              done;
    logic [RATE_W-1:0] rate;
  } kri_iresp_t;

endpackage

[sv/kri_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kri_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module kri_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/kri_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kri_regs
// APB-style register file: blend threshold.
// ----------------------------------------------------------------------------
module kri_regs
  import kri_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [RATE_W-1:0]  thresh_o
);

  logic [RATE_W-1:0] thresh_q, thresh_d;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_THRESH);

  always_comb begin
    thresh_d = thresh_q;
    if (wr_en) begin
      thresh_d = pwdata[RATE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else begin
      thresh_q <= thresh_d;
    end
  end

  assign prdata   = (paddr[2] == REG_THRESH) ? PDATA_W'(thresh_q) : '0;
  assign thresh_o = thresh_q;

endmodule

[sv/kri_interp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kri_interp
// Linear interpolation unit: two multiplies, then a restoring divide that
// retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kri_interp
  import kri_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  kri_ireq_t  req_i,
  output kri_iresp_t resp_o
);

  kri_istate_e state_q, state_d;

  logic [RATE_W-1:0]  rp_q, rp_d, rc_q, rc_d;
  logic [FRAME_W-1:0] span_q, span_d, offs_q, offs_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [FRAME_W-1:0] rem_q, rem_d;
  logic [RATE_W-1:0]  quo_q, quo_d;
  logic [STEP_W-1:0]  step_q, step_d;

  logic [ACC_W-1:0]   num;
  logic [FRAME_W:0]   rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= I_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q   <= rp_d;
    rc_q   <= rc_d;
    span_q <= span_d;
    offs_q <= offs_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  // quotient is known to fit in RATE_W bits, so the top of num is below span
  assign num    = acc_q + ACC_W'(span_q >> 1);
  assign rem_sh = {rem_q, quo_q[RATE_W-1]};

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    rp_d    = rp_q;
    rc_d    = rc_q;
    span_d  = span_q;
    offs_d  = offs_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    resp_o  = '0;
    case (state_q)
      I_IDLE: begin
        if (req_i.start) begin
          rp_d    = req_i.rate_prev;
          rc_d    = req_i.rate_cur;
          span_d  = req_i.span;
          offs_d  = req_i.offs;
          state_d = I_MUL_A;
        end
      end
      I_MUL_A: begin
        acc_d   = ACC_W'(rp_q) * ACC_W'(span_q - offs_q);
        state_d = I_MUL_B;
      end
      I_MUL_B: begin
        acc_d   = acc_q + ACC_W'(rc_q) * ACC_W'(offs_q);
        state_d = I_NORM;
      end
      I_NORM: begin
        rem_d   = num[ACC_W-1:RATE_W];
        quo_d   = num[RATE_W-1:0];
        step_d  = '0;
        state_d = I_DIV;
      end
      I_DIV: begin
        if (rem_sh >= {1'b0, span_q}) begin
          rem_d = FRAME_W'(rem_sh - {1'b0, span_q});
          quo_d = {quo_q[RATE_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[FRAME_W-1:0];
          quo_d = {quo_q[RATE_W-2:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(RATE_W - 1)) begin
          state_d = I_DONE;
        end
      end
      I_DONE: begin
        resp_o.done = 1'b1;
        resp_o.rate = (quo_q > RATE_ONE) ? RATE_ONE : quo_q;
        state_d     = I_IDLE;
      end
      default: begin
        state_d = I_IDLE;
      end
    endcase
  end

endmodule

[sv/kri_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kri_seq
// Request sequencer: key table append/clear, query scan over the key RAM,
// result register toward the output channel.
// ----------------------------------------------------------------------------
module kri_seq
  import kri_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           req_type_i,
  input  logic [FRAME_W-1:0]   key_frame_i,
  input  logic [RATE_W-1:0]    key_rate_i,
  input  logic [FRAME_W-1:0]   query_frame_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [RATE_W-1:0]    rate_o,
  output logic [1:0]           face_action_o,
  output logic [1:0]           status_o,
  input  logic [RATE_W-1:0]    thresh_i,
  output logic                 ram_we_o,
  output logic [KEY_IDX_W-1:0] ram_addr_o,
  output logic [ENTRY_W-1:0]   ram_wdata_o,
  input  logic [ENTRY_W-1:0]   ram_rdata_i,
  output kri_ireq_t            ireq_o,
  input  kri_iresp_t           iresp_i
);

  kri_state_e state_q, state_d;

  logic [KEY_CNT_W-1:0] count_q, count_d;
  logic [KEY_IDX_W-1:0] idx_q, idx_d;
  logic                 out_valid_q, out_valid_d;

  logic [1:0]           req_q, req_d;
  logic [FRAME_W-1:0]   kf_q, kf_d, qf_q, qf_d;
  logic [RATE_W-1:0]    kr_q, kr_d;
  logic [FRAME_W-1:0]   pf_q, pf_d;
  logic [RATE_W-1:0]    pr_q, pr_d;
  logic [RATE_W-1:0]    res_rate_q, res_rate_d, out_rate_q, out_rate_d;
  logic [1:0]           res_act_q, res_act_d, out_act_q, out_act_d;
  logic [1:0]           res_stat_q, res_stat_d, out_stat_q, out_stat_d;

  logic [FRAME_W-1:0]   rd_frame;
  logic [RATE_W-1:0]    rd_rate;
  logic [KEY_IDX_W-1:0] last_idx;
  logic                 in_xfer, out_load;

  assign rd_frame = ram_rdata_i[ENTRY_W-1:RATE_W];
  assign rd_rate  = ram_rdata_i[RATE_W-1:0];
  assign last_idx = KEY_IDX_W'(count_q - 1'b1);

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_RESULT) && (!out_valid_q || out_ready_i);

  function automatic logic [1:0] face_act(input logic [RATE_W-1:0] r,
                                          input logic [RATE_W-1:0] th);
    logic [1:0] a;
    if (r == RATE_ONE) begin
      a = ACT_FULL;
    end else if (r > th) begin
      a = ACT_BLEND;
    end else begin
      a = ACT_NONE;
    end
    return a;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    kf_q       <= kf_d;
    kr_q       <= kr_d;
    qf_q       <= qf_d;
    pf_q       <= pf_d;
    pr_q       <= pr_d;
    res_rate_q <= res_rate_d;
    res_act_q  <= res_act_d;
    res_stat_q <= res_stat_d;
    out_rate_q <= out_rate_d;
    out_act_q  <= out_act_d;
    out_stat_q <= out_stat_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    req_d       = req_q;
    kf_d        = kf_q;
    kr_d        = kr_q;
    qf_d        = qf_q;
    pf_d        = pf_q;
    pr_d        = pr_q;
    res_rate_d  = res_rate_q;
    res_act_d   = res_act_q;
    res_stat_d  = res_stat_q;
    ram_we_o    = 1'b0;
    ram_addr_o  = idx_q;
    ram_wdata_o = {kf_q, (kr_q > RATE_ONE) ? RATE_ONE : kr_q};
    ireq_o      = '0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          req_d   = req_type_i;
          kf_d    = key_frame_i;
          kr_d    = key_rate_i;
          qf_d    = query_frame_i;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        res_rate_d = '0;
        res_act_d  = ACT_NONE;
        res_stat_d = ST_OK;
        state_d    = S_RESULT;
        case (req_q)
          REQ_LOAD: begin
            if (count_q == KEY_CNT_W'(MAX_KEYS)) begin
              res_stat_d = ST_FULL;
            end else begin
              ram_we_o   = 1'b1;
              ram_addr_o = count_q[KEY_IDX_W-1:0];
              count_d    = count_q + 1'b1;
            end
          end
          REQ_CLEAR: begin
            count_d = '0;
          end
          REQ_QUERY: begin
            if (count_q == '0) begin
              res_stat_d = ST_EMPTY;
            end else begin
              ram_addr_o = last_idx;
              state_d    = S_LAST_RD;
            end
          end
          default: begin
          end
        endcase
      end
      S_LAST_RD: begin
        // clamp to the last key's frame, then start the scan at key 0
        if (qf_q > rd_frame) begin
          qf_d = rd_frame;
        end
        ram_addr_o = '0;
        idx_d      = '0;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        if (qf_q <= rd_frame) begin
          if (idx_q == '0) begin
            res_rate_d = rd_rate;
            res_act_d  = face_act(rd_rate, thresh_i);
            res_stat_d = ST_OK;
            state_d    = S_RESULT;
          end else begin
            ireq_o.start     = 1'b1;
            ireq_o.rate_prev = pr_q;
            ireq_o.rate_cur  = rd_rate;
            ireq_o.span      = rd_frame - pf_q;
            ireq_o.offs      = qf_q - pf_q;
            state_d          = S_INTERP;
          end
        end else if (idx_q == last_idx) begin
          // no key at or after q: rate of the last key
          res_rate_d = rd_rate;
          res_act_d  = face_act(rd_rate, thresh_i);
          res_stat_d = ST_OK;
          state_d    = S_RESULT;
        end else begin
          pf_d       = rd_frame;
          pr_d       = rd_rate;
          idx_d      = idx_q + 1'b1;
          ram_addr_o = idx_q + 1'b1;
        end
      end
      S_INTERP: begin
        if (iresp_i.done) begin
          res_rate_d = iresp_i.rate;
          res_act_d  = face_act(iresp_i.rate, thresh_i);
          res_stat_d = ST_OK;
          state_d    = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_rate_d  = out_rate_q;
    out_act_d   = out_act_q;
    out_stat_d  = out_stat_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_rate_d  = res_rate_q;
      out_act_d   = res_act_q;
      out_stat_d  = res_stat_q;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign rate_o        = out_rate_q;
  assign face_action_o = out_act_q;
  assign status_o      = out_stat_q;

endmodule

[sv/keyframe_rate_interpolator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_rate_interpolator_top
// Keyframe table with linear rate interpolation and face action decode.
// ----------------------------------------------------------------------------
// Flow: loads, clears, unknown requests and empty-table queries go from
//   dispatch straight to the result register; a query reads the last key,
//   scans from key 0 to the first key at or after the frame and, unless
//   that is key 0, interpolates before the result register is loaded.
// Requests: one at a time, the next taken as the result goes valid.
// Reset: async, active low; key count to zero, blend threshold to 32.
// ----------------------------------------------------------------------------
module keyframe_rate_interpolator_top
  import kri_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [FRAME_W-1:0] key_frame_i,
  input  logic [RATE_W-1:0]  key_rate_i,
  input  logic [FRAME_W-1:0] query_frame_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [RATE_W-1:0]  rate_o,
  output logic [1:0]         face_action_o,
  output logic [1:0]         status_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // Key RAM entry is {frame, rate}. Only entries below the key count are
  // ever read, so no valid bits or clear sweep are needed.
  logic                 ram_we;
  logic [KEY_IDX_W-1:0] ram_addr;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic [RATE_W-1:0]    thresh;
  kri_ireq_t            ireq;
  kri_iresp_t           iresp;

  kri_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .thresh_o (thresh)
  );

  kri_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_KEYS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Sequencer: accepts a request, walks the key RAM for queries, and
  // holds the result in an output register until transferred.
  kri_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .key_frame_i   (key_frame_i),
    .key_rate_i    (key_rate_i),
    .query_frame_i (query_frame_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .rate_o        (rate_o),
    .face_action_o (face_action_o),
    .status_o      (status_o),
    .thresh_i      (thresh),
    .ram_we_o      (ram_we),
    .ram_addr_o    (ram_addr),
    .ram_wdata_o   (ram_wdata),
    .ram_rdata_i   (ram_rdata),
    .ireq_o        (ireq),
    .iresp_i       (iresp)
  );

  // Interpolator: (rp*(d-n) + rc*n + d/2) / d, rounded half up.
  kri_interp u_interp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ireq),
    .resp_o (iresp)
  );

endmodule

[sv/kri_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kri_checker
// Port-level checks for the keyframe rate interpolator.
// ----------------------------------------------------------------------------
module kri_checker
  import kri_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [RATE_W-1:0]  rate_o,
  input logic [1:0]         face_action_o,
  input logic [1:0]         status_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rate_o))
    else $error("result dropped while stalled");

  // one request in flight
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  a_full_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && face_action_o == ACT_FULL |-> rate_o == RATE_ONE)
    else $error("full-face action without unit rate");

  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> face_action_o == ACT_NONE && rate_o == '0)
    else $error("error result carries rate or action");

  a_rate_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rate_o <= RATE_ONE)
    else $error("rate above one");

endmodule

bind keyframe_rate_interpolator_top kri_checker u_kri_checker (.*);
